@@ src/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared payload types, opcodes and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned ValueBitsDefault = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } out_item_t;

endpackage

@@ src/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply or divide two rationals and reduce to lowest terms.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_ready_o is low until its result is taken
// into the output register. Operands are split into sign and magnitude, the
// cross products are formed one per cycle on a single VB x VB multiplier, the
// gcd is found by a binary gcd loop (one subtract-and-shift per cycle), and
// the two quotients come from one shared restoring divider, one bit per cycle.
module rational_arithmetic_unit #(
  parameter int unsigned VALUE_BITS = rau_pkg::ValueBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rau_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rau_pkg::out_item_t out_data_o
);
  import rau_pkg::*;

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned WW = 2 * VB;
  localparam int unsigned CW = $clog2(WW + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_COMB = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIVN = 9'b001000000,
    S_DIVD = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]    op_q;
  logic [VB-1:0] an_q, ad_q, bn_q, bd_q;
  logic          aneg_q, bneg_q, rneg_q;
  logic [WW-1:0] t1_q, t2_q, den_q, num_q;
  logic [WW-1:0] gx_q, gy_q;
  logic [CW-1:0] gsh_q;
  logic [WW-1:0] g_q;
  logic [WW-1:0] dq_q, drem_q;
  logic [CW-1:0] cnt_q;
  out_item_t     res_q;
  out_item_t     out_q;
  logic          out_valid_q;

  // Magnitude of a field's low VB bits, read as two's complement.
  function automatic logic [VB-1:0] mag_f(input logic [31:0] raw);
    logic [VB-1:0] v;
    v = raw[VB-1:0];
    mag_f = v[VB-1] ? (~v + 1'b1) : v;
  endfunction

  // The one shared multiplier.
  logic [VB-1:0] mul_a, mul_b;
  logic [WW-1:0] mul_p;
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    case (state_q)
      S_MUL0: begin
        mul_a = (op_q == OP_MUL) ? an_q : an_q;
        mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      S_MUL1: begin
        mul_a = ad_q;
        mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
      end
      S_MUL2: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end
  assign mul_p = WW'(mul_a) * WW'(mul_b);

  // Shared divider step: divides num_q or den_q by g_q.
  logic [WW:0]   rem_sh;
  logic [WW-1:0] div_src;
  logic          div_ge;
  assign div_src = (state_q == S_DIVN) ? dq_q : dq_q;
  assign rem_sh  = {drem_q, div_src[WW-1]};
  assign div_ge  = rem_sh >= {1'b0, g_q};

  logic [VB-1:0] ain, aid, bin_m, bid;
  logic          bad_in;
  assign ain   = mag_f(in_data_i.a_num);
  assign aid   = mag_f(in_data_i.a_den);
  assign bin_m = mag_f(in_data_i.b_num);
  assign bid   = mag_f(in_data_i.b_den);
  assign bad_in = (aid == '0) || (bid == '0) ||
                  ((in_data_i.op == OP_DIV) && (bin_m == '0));

  logic [WW-1:0] lim;
  assign lim = WW'(1) << (VB - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i && in_ready_o) state_d = bad_in ? S_DONE : S_MUL0;
      S_MUL0:  state_d = S_MUL1;
      S_MUL1:  state_d = (op_q == OP_ADD || op_q == OP_SUB) ? S_MUL2 : S_COMB;
      S_MUL2:  state_d = S_COMB;
      S_COMB:  state_d = S_GCD;
      S_GCD:   if (gy_q == '0) state_d = S_DIVN;
      S_DIVN:  if (cnt_q == '0) state_d = S_DIVD;
      S_DIVD:  if (cnt_q == '0) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q <= in_data_i.op;
        an_q <= ain;
        ad_q <= aid;
        bn_q <= bin_m;
        bd_q <= bid;
        aneg_q <= (in_data_i.a_num[VB-1] != in_data_i.a_den[VB-1]) && (ain != '0);
        bneg_q <= (in_data_i.b_num[VB-1] != in_data_i.b_den[VB-1]) && (bin_m != '0);
        if (bad_in) begin
          res_q.res_num <= '0;
          res_q.res_den <= 31'd1;
          res_q.status  <= ST_ZERO_DEN;
        end
      end
      S_MUL0: begin
        t1_q <= mul_p;
        if (op_q == OP_SUB && bn_q != '0) bneg_q <= ~bneg_q;
      end
      S_MUL1: den_q <= mul_p;
      S_MUL2: t2_q <= mul_p;
      S_COMB: begin
        logic [WW-1:0] n;
        logic          r;
        n = t1_q;
        r = aneg_q != bneg_q;
        if (op_q == OP_ADD || op_q == OP_SUB) begin
          if (aneg_q == bneg_q) begin
            n = t1_q + t2_q;
            r = aneg_q;
          end else if (t1_q >= t2_q) begin
            n = t1_q - t2_q;
            r = aneg_q;
          end else begin
            n = t2_q - t1_q;
            r = bneg_q;
          end
        end
        if (n == '0) begin
          r = 1'b0;
          den_q <= WW'(1);
          gx_q  <= WW'(1);
        end else begin
          gx_q <= n;
        end
        num_q  <= n;
        rneg_q <= r;
        gy_q   <= (n == '0) ? '0 : den_q;
        gsh_q  <= '0;
      end
      S_GCD: begin
        // Binary gcd; gy_q reaches zero and gx_q << gsh_q is the gcd.
        if (gy_q == '0) begin
          g_q    <= gx_q << gsh_q;
          dq_q   <= num_q;
          drem_q <= '0;
          cnt_q  <= CW'(WW - 1);
        end else if (!gx_q[0] && !gy_q[0]) begin
          gx_q  <= gx_q >> 1;
          gy_q  <= gy_q >> 1;
          gsh_q <= gsh_q + 1'b1;
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else if (gx_q >= gy_q) begin
          gx_q <= gy_q;
          gy_q <= (gx_q - gy_q) >> 1;
        end else begin
          gy_q <= (gy_q - gx_q) >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        logic [WW-1:0] nr;
        nr = div_ge ? WW'(rem_sh - {1'b0, g_q}) : rem_sh[WW-1:0];
        if (cnt_q == '0) begin
          if (state_q == S_DIVN) begin
            num_q  <= {dq_q[WW-2:0], div_ge};
            dq_q   <= den_q;
            drem_q <= '0;
            cnt_q  <= CW'(WW - 1);
          end else begin
            logic [WW-1:0] dd;
            dd = {dq_q[WW-2:0], div_ge};
            if ((rneg_q ? (num_q > lim) : (num_q > lim - 1'b1)) || dd > lim - 1'b1) begin
              res_q.res_num <= '0;
              res_q.res_den <= 31'd1;
              res_q.status  <= ST_OVERFLOW;
            end else begin
              res_q.res_num <= 32'(signed'(VB'(rneg_q ? (~num_q + 1'b1) : num_q)));
              res_q.res_den <= 31'(dd);
              res_q.status  <= ST_OK;
            end
          end
        end else begin
          dq_q   <= {dq_q[WW-2:0], div_ge};
          drem_q <= nr;
          cnt_q  <= cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        // The finished item moves to the output register once it is free.
        if (!out_valid_q || out_ready_i) out_q <= res_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
